[rtl/core/idra_pkg.sv]
package idra_pkg;

  localparam int WORD_W  = 64;
  localparam int WORD_BW = 6;
  localparam logic [16:0] SWAP_SPAN = 17'd10000;

  localparam logic [2:0] ADDR_RANGE_LOW  = 3'd0;
  localparam logic [2:0] ADDR_RANGE_HIGH = 3'd4;

  typedef enum logic [1:0] {
    CMD_RESERVE    = 2'd0,
    CMD_RELEASE    = 2'd1,
    CMD_ALLOC_LOW  = 2'd2,
    CMD_ALLOC_NEXT = 2'd3
  } cmd_t;

  // one classified item as it sits in the queue
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] id;
    logic [15:0] bound;
    logic [16:0] n;
    logic        inr;
  } entry_t;

  // effective upper bound of the range, clamped to the map and to 16 bits
  function automatic logic [15:0] upper_bound(input logic [15:0] lo, input logic [15:0] hi,
                                              input logic [16:0] space);
    logic [17:0] b;
    logic [17:0] cap;
    b   = (lo > hi) ? (18'(lo) + 18'(SWAP_SPAN)) : 18'(hi);
    cap = 18'(lo) + 18'(space) + 18'd1;
    if (b > cap) b = cap;
    if (b > 18'd65535) b = 18'd65535;
    return b[15:0];
  endfunction

endpackage

[rtl/core/idra_if.sv]
interface idra_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] id_in;
  modport source (output valid, command, id_in, input ready);
  modport sink   (input valid, command, id_in, output ready);
endinterface

interface idra_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] id_out;
  modport source (output valid, ok, id_out, input ready);
  modport sink   (input valid, ok, id_out, output ready);
endinterface

[rtl/core/idra_ram.sv]
module idra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/idra_front.sv]
module idra_front import idra_pkg::*; #(
  parameter int ID_SPACE = 1024
) (
  idra_in_if.sink     in_ch,
  input  logic [15:0] range_low,
  input  logic [15:0] range_high,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_ent
);

  logic [15:0] bound;

  assign bound = upper_bound(range_low, range_high, 17'(ID_SPACE));

  always_comb begin
    q_ent.cmd   = cmd_t'(in_ch.command);
    q_ent.id    = in_ch.id_in;
    q_ent.bound = bound;
    q_ent.n     = (17'(bound) > 17'(range_low) + 17'd1) ?
                  (17'(bound) - 17'(range_low) - 17'd1) : 17'd0;
    q_ent.inr   = (in_ch.id_in > range_low) && (in_ch.id_in < bound);
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

endmodule

[rtl/core/idra_fifo.sv]
module idra_fifo #(
  parameter int WIDTH = 52
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             vld,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= wdata;
        wp_r        <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign full  = cnt_r[1];
  assign vld   = cnt_r != 2'd0;
  assign rdata = mem_r[rp_r];

endmodule

[rtl/core/idra_back.sv]
module idra_back import idra_pkg::*; #(
  parameter int ID_SPACE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic [15:0] clr_bound,
  input  logic [15:0] range_low,
  input  logic        q_vld,
  input  entry_t      q_ent,
  output logic        q_pop,
  idra_out_if.source  out_ch
);

  localparam int NW  = (ID_SPACE + WORD_W - 1) / WORD_W;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam int WCW = $clog2(NW + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RW, ST_SCAN} state_t;

  state_t           st_r;
  entry_t           ent_r;
  logic             pass_r;
  logic [16:0]      start_r;
  logic [WCW-1:0]   iss_r;
  logic             chk_vld_r;
  logic [WCW-1:0]   chk_w_r;
  logic [WAW-1:0]   rd_a_r;
  logic [15:0]      last_r;
  logic [NW-1:0]    rowv_r;
  logic             out_vld_r, out_ok_r;
  logic [15:0]      out_id_r;

  logic             re, we;
  logic [WAW-1:0]   raddr, waddr;
  logic [WORD_W-1:0] wdata, rdata, eff;
  logic [15:0]      pidx, widx;
  logic [WCW-1:0]   nwe;
  logic             issue, found, lg_in, out_free;
  logic [16:0]      wx, sw, nw;
  logic [WORD_W-1:0] lo_m, hi_m, free;
  logic [WORD_BW-1:0] fb;
  logic [15:0]      take_id;

  idra_ram #(.WIDTH(WORD_W), .DEPTH(NW)) u_ram (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  assign out_free = !out_vld_r || out_ch.ready;
  assign q_pop    = (st_r == ST_IDLE) && q_vld && out_free;
  assign pidx     = q_ent.id - range_low - 16'd1;
  assign widx     = ent_r.id - range_low - 16'd1;
  assign nwe      = WCW'((ent_r.n + 17'd63) >> WORD_BW);
  assign lg_in    = (last_r > range_low) && (last_r < q_ent.bound);
  assign eff      = rowv_r[rd_a_r] ? rdata : '0;

  // candidate mask of the word under check: bits at or above start, below n
  always_comb begin
    wx   = 17'(chk_w_r);
    sw   = start_r >> WORD_BW;
    nw   = ent_r.n >> WORD_BW;
    lo_m = (wx > sw) ? '1 : ((wx == sw) ? ('1 << start_r[WORD_BW-1:0]) : '0);
    hi_m = (wx < nw) ? '1 :
           ((wx == nw) ? ((WORD_W'(1) << ent_r.n[WORD_BW-1:0]) - WORD_W'(1)) : '0);
    free = ~eff & lo_m & hi_m;
    fb   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free[b]) fb = WORD_BW'(b);
    end
  end

  assign found   = (st_r == ST_SCAN) && chk_vld_r && (|free);
  assign issue   = (st_r == ST_SCAN) && (iss_r < nwe) && !found;
  assign take_id = range_low + 16'd1 + 16'({chk_w_r, fb});

  always_comb begin
    re    = issue;
    raddr = iss_r[WAW-1:0];
    if (q_pop && (q_ent.cmd == CMD_RESERVE || q_ent.cmd == CMD_RELEASE)) begin
      re    = q_ent.inr;
      raddr = WAW'(pidx >> WORD_BW);
    end
    we    = 1'b0;
    waddr = rd_a_r;
    wdata = eff;
    if (st_r == ST_RW) begin
      if (ent_r.cmd == CMD_RESERVE) begin
        we    = 1'b1;
        wdata = eff | (WORD_W'(1) << widx[WORD_BW-1:0]);
      end else begin
        we    = eff[widx[WORD_BW-1:0]];
        wdata = eff & ~(WORD_W'(1) << widx[WORD_BW-1:0]);
      end
    end else if (found) begin
      we    = 1'b1;
      wdata = eff | (WORD_W'(1) << fb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      chk_vld_r <= 1'b0;
      last_r    <= upper_bound(16'd0, 16'd1024, 17'(ID_SPACE));
      rowv_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      chk_vld_r <= issue;
      if (re) rd_a_r <= raddr;
      if (issue) begin
        chk_w_r <= iss_r;
        iss_r   <= iss_r + WCW'(1);
      end
      if (we) rowv_r[waddr] <= 1'b1;
      if (out_ch.ready) out_vld_r <= 1'b0;
      if (clr) begin
        rowv_r <= '0;
        last_r <= clr_bound;
      end
      case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            ent_r <= q_ent;
            if (q_ent.cmd == CMD_RESERVE || q_ent.cmd == CMD_RELEASE) begin
              if (q_ent.inr) begin
                st_r <= ST_RW;
              end else begin
                out_vld_r <= 1'b1;
                out_ok_r  <= 1'b0;
                out_id_r  <= q_ent.id;
              end
            end else begin
              st_r <= ST_SCAN;
              if (q_ent.cmd == CMD_ALLOC_NEXT && lg_in) begin
                pass_r  <= 1'b0;
                start_r <= 17'(last_r) - 17'(range_low);
                iss_r   <= WCW'((17'(last_r) - 17'(range_low)) >> WORD_BW);
              end else begin
                pass_r  <= 1'b1;
                start_r <= '0;
                iss_r   <= '0;
              end
            end
          end
        end
        ST_RW: begin
          out_vld_r <= 1'b1;
          out_id_r  <= ent_r.id;
          out_ok_r  <= (ent_r.cmd == CMD_RESERVE) || eff[widx[WORD_BW-1:0]];
          if (ent_r.cmd == CMD_RESERVE) last_r <= ent_r.id;
          st_r <= ST_IDLE;
        end
        ST_SCAN: begin
          if (found) begin
            last_r    <= take_id;
            out_vld_r <= 1'b1;
            out_ok_r  <= 1'b1;
            out_id_r  <= take_id;
            st_r      <= ST_IDLE;
          end else if (!issue && !chk_vld_r) begin
            if (!pass_r) begin
              // nothing above last one handed out: wrap to the bottom
              pass_r  <= 1'b1;
              start_r <= '0;
              iss_r   <= '0;
            end else begin
              out_vld_r <= 1'b1;
              out_ok_r  <= 1'b0;
              out_id_r  <= ent_r.bound;
              st_r      <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.ok     = out_ok_r;
  assign out_ch.id_out = out_id_r;

endmodule

[rtl/core/id_range_allocator_core.sv]
// ID allocator over a used-bit map kept in 64-bit words of a single-port-read RAM.
// Reserve and release go through the back end as a word read, then a word write.
// Allocation scans the map one word per cycle through the RAM read port; a next-fit
// allocation that wraps scans it twice, first above the last ID handed out,
// then from the bottom of the range. A two-entry queue sits between the classifying
// front end and the back end. Results wait in an output register,
// and the back end takes the next item no earlier than the cycle in which the
// waiting result is taken. Config writes (APB, range_low at 0x0, range_high at
// 0x4) clear the map at once and must be issued while idle.
module id_range_allocator_core import idra_pkg::*; #(
  parameter int ID_SPACE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  idra_in_if.sink     in_ch,
  idra_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] range_low_r, range_high_r, low_nxt, high_nxt;
  logic        wr, wr_low, wr_high, clr;
  logic        q_push, q_full, q_pop, q_vld;
  entry_t      q_in, q_out;

  assign cfg_pready = 1'b1;
  assign wr       = cfg_psel && cfg_penable && cfg_pwrite;
  assign wr_low   = wr && (cfg_paddr == ADDR_RANGE_LOW);
  assign wr_high  = wr && (cfg_paddr == ADDR_RANGE_HIGH);
  assign clr      = wr_low || wr_high;
  assign low_nxt  = wr_low ? cfg_pwdata[15:0] : range_low_r;
  assign high_nxt = wr_high ? cfg_pwdata[15:0] : range_high_r;

  always_comb begin
    case (cfg_paddr)
      ADDR_RANGE_LOW:  cfg_prdata = 32'(range_low_r);
      ADDR_RANGE_HIGH: cfg_prdata = 32'(range_high_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= 16'd0;
      range_high_r <= 16'd1024;
    end else begin
      range_low_r  <= low_nxt;
      range_high_r <= high_nxt;
    end
  end

  idra_front #(.ID_SPACE(ID_SPACE)) u_front (
    .in_ch, .range_low(range_low_r), .range_high(range_high_r),
    .q_full, .q_push, .q_ent(q_in)
  );

  idra_fifo #(.WIDTH($bits(entry_t))) u_fifo (
    .clk, .rst_n, .push(q_push), .wdata(q_in), .full(q_full),
    .pop(q_pop), .vld(q_vld), .rdata(q_out)
  );

  idra_back #(.ID_SPACE(ID_SPACE)) u_back (
    .clk, .rst_n, .clr,
    .clr_bound(upper_bound(low_nxt, high_nxt, 17'(ID_SPACE))),
    .range_low(range_low_r), .q_vld, .q_ent(q_out), .q_pop, .out_ch
  );

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import idra_pkg::*;

  localparam int MAP_SIZE    = 1024;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 80;

  typedef struct packed {
    logic        ok;
    logic [15:0] id;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  idra_in_if  in_ch();
  idra_out_if out_ch();

  id_range_allocator_core #(.ID_SPACE(MAP_SIZE)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // shadow of the allocator state
  logic [15:0] shadow_low;
  logic [15:0] shadow_high;
  logic [15:0] shadow_last;
  bit          shadow_used [MAP_SIZE];

  grant_t pending_grants[$];
  int     mismatches;
  int     stall_cycles;
  int     holdoff_cnt;
  int     rx_gap;
  bit     no_idle;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [15:0] range_top();
    logic [17:0] b;
    logic [17:0] cap;
    b   = (shadow_low > shadow_high) ? 18'(shadow_low) + 18'(SWAP_SPAN) : 18'(shadow_high);
    cap = 18'(shadow_low) + 18'(MAP_SIZE) + 18'd1;
    if (b > cap) b = cap;
    if (b > 18'd65535) b = 18'd65535;
    return b[15:0];
  endfunction

  function automatic int free_slots_total();
    int top;
    top = range_top();
    return (top > int'(shadow_low) + 1) ? top - int'(shadow_low) - 1 : 0;
  endfunction

  function automatic int first_free_from(int start);
    int n;
    n = free_slots_total();
    for (int i = start; i < n; i++) if (!shadow_used[i]) return i;
    return n;
  endfunction

  function automatic void clear_shadow();
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    shadow_last = range_top();
  endfunction

  function automatic grant_t predict_grant(cmd_t c, logic [15:0] id);
    grant_t g;
    int n, idx, top;
    n   = free_slots_total();
    top = range_top();
    if (c == CMD_RESERVE || c == CMD_RELEASE) begin
      g.ok = 1'b0;
      g.id = id;
      if (id > shadow_low && id < top) begin
        idx = id - shadow_low - 1;
        if (c == CMD_RESERVE) begin
          shadow_used[idx] = 1'b1;
          shadow_last = id;
          g.ok = 1'b1;
        end else if (shadow_used[idx]) begin
          shadow_used[idx] = 1'b0;
          g.ok = 1'b1;
        end
      end
      return g;
    end
    idx = n;
    if (c == CMD_ALLOC_NEXT && shadow_last > shadow_low && shadow_last < top)
      idx = first_free_from(shadow_last - shadow_low);
    if (idx >= n) idx = first_free_from(0);
    if (idx >= n) begin
      g.ok = 1'b0;
      g.id = 16'(top);
    end else begin
      shadow_used[idx] = 1'b1;
      shadow_last = 16'(int'(shadow_low) + 1 + idx);
      g.ok = 1'b1;
      g.id = shadow_last;
    end
    return g;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stalls plus an explicit long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (holdoff_cnt > 0) begin
      out_ch.ready = 1'b0;
      holdoff_cnt--;
    end else if (no_idle) begin
      out_ch.ready = 1'b1;
    end else if (rx_gap > 0) begin
      out_ch.ready = 1'b0;
      rx_gap--;
    end else begin
      rx_gap = pick_gap();
      out_ch.ready = (rx_gap == 0);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    grant_t want;
    if (rst_n) begin
      stall_cycles++;
      if (in_ch.valid && in_ch.ready) stall_cycles = 0;
      if (cfg_psel && cfg_penable) stall_cycles = 0;
      if (out_ch.valid && out_ch.ready) begin
        stall_cycles = 0;
        if (pending_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat ok=%0b id=%0d", out_ch.ok, out_ch.id_out);
        end else begin
          want = pending_grants.pop_front();
          if (out_ch.ok !== want.ok || out_ch.id_out !== want.id) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected ok=%0b id=%0d, got ok=%0b id=%0d",
                       want.ok, want.id, out_ch.ok, out_ch.id_out);
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(cmd_t c, logic [15:0] id);
    int g;
    g = no_idle ? 0 : pick_gap();
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.command = c;
    in_ch.id_in   = id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_grants.push_back(predict_grant(c, id));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [15:0] val);
    wait_drained();
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = 32'(val);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == ADDR_RANGE_LOW) shadow_low = val;
    else shadow_high = val;
    clear_shadow();
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_range(logic [15:0] lo, logic [15:0] hi);
    write_reg(ADDR_RANGE_LOW, lo);
    write_reg(ADDR_RANGE_HIGH, hi);
  endtask

  function automatic logic [15:0] random_id();
    int r, n;
    r = $urandom_range(0, 9);
    n = free_slots_total();
    if (r == 0 || n == 0) return 16'($urandom);
    if (r == 1) return $urandom_range(0, 1) ? shadow_low : range_top();
    if (r == 2) return 16'(int'(shadow_low) + ($urandom_range(0, 1) ? 1 : n));
    return 16'(int'(shadow_low) + 1 + $urandom_range(0, n - 1));
  endfunction

  function automatic cmd_t random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return CMD_RESERVE;
    if (r < 55) return CMD_RELEASE;
    if (r < 75) return CMD_ALLOC_LOW;
    return CMD_ALLOC_NEXT;
  endfunction

  task automatic test_directed();
    send_cmd(CMD_RESERVE, 16'd0);
    send_cmd(CMD_RESERVE, 16'd1);
    send_cmd(CMD_RESERVE, 16'd1023);
    send_cmd(CMD_RESERVE, 16'd1024);
    send_cmd(CMD_RESERVE, 16'hFFFF);
    send_cmd(CMD_RESERVE, 16'd1);
    send_cmd(CMD_RELEASE, 16'd5);
    send_cmd(CMD_RELEASE, 16'hFFFF);
    send_cmd(CMD_ALLOC_NEXT, 16'hFFFF);
    send_cmd(CMD_ALLOC_LOW, 16'h0000);
    send_cmd(CMD_RELEASE, 16'd1);
    send_cmd(CMD_ALLOC_NEXT, 16'd0);
    // two usable IDs: fill, full, free one, wrap
    set_range(16'd100, 16'd103);
    send_cmd(CMD_ALLOC_NEXT, 16'd0);
    send_cmd(CMD_ALLOC_NEXT, 16'd0);
    send_cmd(CMD_ALLOC_NEXT, 16'd0);
    send_cmd(CMD_RELEASE, 16'd101);
    send_cmd(CMD_ALLOC_NEXT, 16'd0);
    send_cmd(CMD_ALLOC_LOW, 16'd0);
    // empty range
    set_range(16'd7, 16'd8);
    send_cmd(CMD_RESERVE, 16'd8);
    send_cmd(CMD_RELEASE, 16'd7);
    send_cmd(CMD_ALLOC_LOW, 16'd0);
    send_cmd(CMD_ALLOC_NEXT, 16'd0);
  endtask

  task automatic test_random_range(logic [15:0] lo, logic [15:0] hi, int count);
    set_range(lo, hi);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) send_cmd(random_cmd(), random_id());
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    set_range(16'd0, 16'd40);
    holdoff_cnt = 400;
    for (int i = 0; i < 30; i++) send_cmd(random_cmd(), random_id());
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_RESERVE;
    in_ch.id_in = 16'd0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = ADDR_RANGE_LOW;
    cfg_pwdata = 32'd0;
    mismatches = 0;
    stall_cycles = 0;
    holdoff_cnt = 0;
    rx_gap = 0;
    no_idle = 1'b0;
    shadow_low = 16'd0;
    shadow_high = 16'd1024;
    clear_shadow();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_range(16'd0, 16'd1024, 260);
    test_random_range(16'd100, 16'd105, 180);
    test_random_range(16'd65530, 16'd65535, 160);
    test_random_range(16'd500, 16'd400, 220);
    test_random_range(16'd0, 16'd65535, 240);
    test_random_range(16'd65535, 16'd0, 60);
    test_random_range(16'd7, 16'd7, 60);
    test_random_range(16'd3000, 16'd3100, 240);
    test_backpressure();
    test_random_range(16'd65000, 16'd300, 220);

    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
